// ===== hdl/sha256_byte_stream_hasher_unit_assert.svh =====
// Assertion macros for the SHA-256 byte stream hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SHB_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define SHB_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== hdl/shb_pkg.sv =====
package shb_pkg;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } beat_t;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;

    localparam logic [7:0] PadMark = 8'h80;

    localparam word_t RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t StartHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== hdl/shb_front.sv =====
// Input stage: drops empty non-last beats and queues the rest.
module shb_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       data_byte,
    input  logic             has_byte,
    input  logic             is_last,
    input  logic             valid,
    output logic             stall,
    output shb_pkg::beat_t   q_beat,
    output logic             q_valid,
    input  logic             q_pop
);

    shb_pkg::beat_t mem_reg [shb_pkg::QueueDepth];
    logic [shb_pkg::QueuePtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [shb_pkg::QueuePtrW:0]   count_reg, count_next;
    logic push, keep;

    assign stall = (count_reg == 3'(shb_pkg::QueueDepth));
    assign keep  = has_byte | is_last;
    assign push  = valid & ~stall & keep;
    assign q_valid = (count_reg != '0);
    assign q_beat  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + {2'b0, push} - {2'b0, q_pop & q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop & q_valid)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= '{data_byte: data_byte, has_byte: has_byte,
                                     is_last: is_last};
    end

endmodule

// ===== hdl/shb_back.sv =====
// Block assembly, padding, one-round-per-cycle compression, digest output.
module shb_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  shb_pkg::beat_t  q_beat,
    input  logic            q_valid,
    output logic            q_pop,
    output logic [31:0]     digest_word,
    output logic [2:0]      word_index,
    output logic            last_word,
    output logic            valid,
    input  logic            stall
);

    typedef enum logic [4:0] {
        ST_TAKE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_ROUND = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    shb_pkg::word_t chain_reg [8];
    shb_pkg::word_t v_reg [8];
    shb_pkg::word_t w_reg [16];   // message block, then schedule window
    logic [60:0] count_reg;
    logic [5:0]  pad_pos_reg;
    logic [5:0]  rnd_reg;
    logic        final_reg;       // compression is the message's last
    logic        pend_last_reg;   // last came with the 64th byte of a block
    logic        two_blk_reg;     // padding spills into a second block
    logic        mark_reg;        // next pad byte is the 0x80 mark
    logic [2:0]  oidx_reg;
    logic        ovalid_reg;
    logic [31:0] oword_reg;

    shb_pkg::word_t t1, t2, s0, s1, w_new, w_cur;
    logic [63:0] bits;
    logic [5:0]  wpos;
    logic [5:0]  last_pos;
    logic [7:0]  pad_byte;
    logic        take, blk_full, out_move;

    assign bits = {count_reg, 3'b000};
    assign w_cur = w_reg[0];

    always_comb
    begin
        s0 = shb_pkg::rotr(w_reg[1], 7) ^ shb_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = shb_pkg::rotr(w_reg[14], 17) ^ shb_pkg::rotr(w_reg[14], 19)
             ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        t1 = v_reg[7] + (shb_pkg::rotr(v_reg[4], 6) ^ shb_pkg::rotr(v_reg[4], 11)
             ^ shb_pkg::rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + shb_pkg::RoundK[rnd_reg] + w_cur;
        t2 = (shb_pkg::rotr(v_reg[0], 2) ^ shb_pkg::rotr(v_reg[0], 13)
             ^ shb_pkg::rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign q_pop    = (state_reg == ST_TAKE);
    assign wpos     = count_reg[5:0];
    assign take     = (state_reg == ST_TAKE) && q_valid;
    assign blk_full = q_beat.has_byte && (wpos == 6'd63);
    assign last_pos = q_beat.has_byte ? wpos + 6'd1 : wpos;
    assign out_move = !(ovalid_reg && stall);

    assign digest_word = oword_reg;
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 3'd7);
    assign valid       = ovalid_reg;

    // Pad byte: mark first, length in the last eight bytes of the final block.
    always_comb
    begin
        if (mark_reg)
            pad_byte = shb_pkg::PadMark;
        else if (!two_blk_reg && pad_pos_reg >= 6'd56)
            pad_byte = bits[{~pad_pos_reg[2:0], 3'b111} -: 8];
        else
            pad_byte = 8'h00;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_TAKE:
                if (q_valid)
                begin
                    if (blk_full)
                        state_next = ST_LOAD;
                    else if (q_beat.is_last)
                        state_next = ST_PAD;
                end
            ST_PAD:   if (pad_pos_reg == 6'd63) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND:
                if (rnd_reg == 6'd63)
                begin
                    if (final_reg)
                        state_next = ST_OUT;
                    else if (two_blk_reg || pend_last_reg)
                        state_next = ST_PAD;
                    else
                        state_next = ST_TAKE;
                end
            ST_OUT:
                if (out_move && ovalid_reg && oidx_reg == 3'd7)
                    state_next = ST_TAKE;
            default: state_next = ST_TAKE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_TAKE;
            count_reg     <= '0;
            pad_pos_reg   <= '0;
            rnd_reg       <= '0;
            final_reg     <= 1'b0;
            pend_last_reg <= 1'b0;
            two_blk_reg   <= 1'b0;
            mark_reg      <= 1'b0;
            oidx_reg      <= '0;
            ovalid_reg    <= 1'b0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= shb_pkg::StartHash[i];
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_TAKE:
                    if (q_valid)
                    begin
                        if (q_beat.has_byte)
                            count_reg <= count_reg + 61'd1;
                        if (blk_full)
                            pend_last_reg <= q_beat.is_last;
                        else if (q_beat.is_last)
                        begin
                            pad_pos_reg <= last_pos;
                            two_blk_reg <= (last_pos > 6'd55);
                            mark_reg    <= 1'b1;
                        end
                    end
                ST_PAD:
                begin
                    mark_reg <= 1'b0;
                    if (pad_pos_reg == 6'd63)
                    begin
                        pad_pos_reg <= '0;
                        final_reg   <= !two_blk_reg;
                    end
                    else
                        pad_pos_reg <= pad_pos_reg + 6'd1;
                end
                ST_LOAD:
                    rnd_reg <= '0;
                ST_ROUND:
                    if (rnd_reg == 6'd63)
                    begin
                        chain_reg[0] <= chain_reg[0] + t1 + t2;
                        chain_reg[1] <= chain_reg[1] + v_reg[0];
                        chain_reg[2] <= chain_reg[2] + v_reg[1];
                        chain_reg[3] <= chain_reg[3] + v_reg[2];
                        chain_reg[4] <= chain_reg[4] + v_reg[3] + t1;
                        chain_reg[5] <= chain_reg[5] + v_reg[4];
                        chain_reg[6] <= chain_reg[6] + v_reg[5];
                        chain_reg[7] <= chain_reg[7] + v_reg[6];
                        rnd_reg   <= '0;
                        final_reg <= 1'b0;
                        // second pad block: zeros and length only
                        if (two_blk_reg)
                            two_blk_reg <= 1'b0;
                        else if (pend_last_reg)
                        begin
                            pend_last_reg <= 1'b0;
                            mark_reg      <= 1'b1;
                        end
                    end
                    else
                        rnd_reg <= rnd_reg + 6'd1;
                ST_OUT:
                    if (out_move)
                    begin
                        if (ovalid_reg && oidx_reg == 3'd7)
                        begin
                            ovalid_reg <= 1'b0;
                            oidx_reg   <= '0;
                            count_reg  <= '0;
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= shb_pkg::StartHash[i];
                        end
                        else
                        begin
                            if (ovalid_reg)
                                oidx_reg <= oidx_reg + 3'd1;
                            ovalid_reg <= 1'b1;
                        end
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && q_beat.has_byte)
            w_reg[wpos[5:2]][{~wpos[1:0], 3'b000} +: 8] <= q_beat.data_byte;
        else if (state_reg == ST_PAD)
            w_reg[pad_pos_reg[5:2]][{~pad_pos_reg[1:0], 3'b000} +: 8] <= pad_byte;
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
        end
        if (state_reg == ST_LOAD)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= chain_reg[i];
        end
        else if (state_reg == ST_ROUND)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (state_reg == ST_OUT && out_move)
            oword_reg <= chain_reg[ovalid_reg ? oidx_reg + 3'd1 : 3'd0];
    end

endmodule

// ===== hdl/sha256_byte_stream_hasher_unit.sv =====
// SHA-256 hasher over a byte stream.
// Input channel: data_byte/has_byte/is_last with in_valid/in_stall. A beat with
// has_byte set appends one byte; is_last ends the message (with or without a
// byte). Beats with neither flag are taken and dropped.
// Output channel: digest_word/word_index/last_word with out_valid/out_stall;
// eight beats per message, word 0 first, last_word on word 7.
// A four-entry queue decouples input from the hashing engine, so the input
// keeps taking beats while a compression runs until the queue fills.
// Throughput: one byte per cycle inside a block; the 64th byte of a block holds
// the engine while it loads the working variables and runs the rounds, one per cycle.
// On is_last the engine writes padding from byte offset p (bytes in the open
// block) to the block end, then compresses; when p > 55 a second block is
// padded and compressed as well. The first digest word is then loaded into
// the output register; words go out at one per cycle while out_stall is low.
// Receiver stall holds the current digest word; the engine waits with it.
// Reset (rst_n low, async) empties the queue, restores the initial hash
// values and clears the byte count.
module sha256_byte_stream_hasher_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        is_last,
    input  logic        in_valid,
    output logic        in_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    output logic        out_valid,
    input  logic        out_stall
);

    shb_pkg::beat_t q_beat;
    logic           q_valid;
    logic           q_pop;

    shb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .is_last   (is_last),
        .valid     (in_valid),
        .stall     (in_stall),
        .q_beat    (q_beat),
        .q_valid   (q_valid),
        .q_pop     (q_pop)
    );

    shb_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_beat      (q_beat),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word),
        .valid       (out_valid),
        .stall       (out_stall)
    );

endmodule

// ===== hdl/shb_checker.sv =====
`include "sha256_byte_stream_hasher_unit_assert.svh"

module shb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word,
    input logic        out_valid,
    input logic        out_stall
);

    `SHB_ASSERT_IMPL(a_last_is_seven, clk, rst_n, out_valid, last_word == (word_index == 3'd7), "last_word mismatch")
    `SHB_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(digest_word) && $stable(word_index), "stalled beat changed")
    `SHB_ASSERT_NEXT(a_step, clk, rst_n, out_valid && !out_stall && !last_word, out_valid && word_index == $past(word_index) + 3'd1, "word order broken")

endmodule

bind sha256_byte_stream_hasher_unit shb_checker u_shb_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
);

// ===== verif/tb_sha256_byte_stream_hasher_unit.sv =====
module tb_sha256_byte_stream_hasher_unit;

    // One expected digest beat.
    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    // Digest predictor plus the queue of digest beats still owed by the block.
    class sha_digest_scoreboard;
        logic [31:0]  chain [8];
        logic [7:0]   blk [64];
        logic [60:0]  nbytes;
        digest_beat_t owed_q [$];
        int           errors;

        function new();
            errors = 0;
            foreach (blk[i]) blk[i] = 8'h00;
            restart();
        endfunction

        function void restart();
            foreach (chain[i]) chain[i] = shb_pkg::StartHash[i];
            nbytes = '0;
        endfunction

        function logic [31:0] ror32(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] s0, s1, t1, t2, ch, mj;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++)
            begin
                s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = s1 + w[i-7] + s0 + w[i-16];
            end
            foreach (v[i]) v[i] = chain[i];
            for (int i = 0; i < 64; i++)
            begin
                ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
                t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                     + ch + shb_pkg::RoundK[i] + w[i];
                mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
                t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) + mj;
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            foreach (chain[i]) chain[i] += v[i];
        endfunction

        // Accepted input beat: append byte, finish message on last.
        function void note_beat(logic [7:0] d, logic h, logic l);
            int           pos;
            logic [63:0]  bits;
            digest_beat_t db;
            if (h)
            begin
                blk[nbytes[5:0]] = d;
                nbytes = nbytes + 61'd1;
                if (nbytes[5:0] == 6'd0) compress();
            end
            if (!l) return;
            pos = int'(nbytes[5:0]);
            blk[pos] = shb_pkg::PadMark;
            pos++;
            if (pos > 56)
            begin
                while (pos < 64) begin blk[pos] = 8'h00; pos++; end
                compress();
                pos = 0;
            end
            while (pos < 56) begin blk[pos] = 8'h00; pos++; end
            bits = {nbytes, 3'b000};
            for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++)
            begin
                db.word  = chain[i];
                db.index = i[2:0];
                db.last  = (i == 7);
                owed_q.push_back(db);
            end
            restart();
        endfunction

        function void check_word(logic [31:0] w, logic [2:0] idx, logic lw);
            digest_beat_t db;
            if (owed_q.size() == 0)
            begin
                $display("%0t: unexpected digest beat word=%h index=%0d last=%b",
                         $time, w, idx, lw);
                errors++;
                return;
            end
            db = owed_q.pop_front();
            if (w !== db.word)
            begin
                $display("%0t: digest_word exp %h got %h", $time, db.word, w);
                errors++;
            end
            if (idx !== db.index)
            begin
                $display("%0t: word_index exp %0d got %0d", $time, db.index, idx);
                errors++;
            end
            if (lw !== db.last)
            begin
                $display("%0t: last_word exp %b got %b", $time, db.last, lw);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        has_byte = 1'b0;
    logic        is_last = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        out_valid;
    logic        out_stall = 1'b0;

    sha_digest_scoreboard sb = new();

    int cycle_count = 0;
    int burst_left = 0;
    int item_count = 0;

    localparam int CycleLimit = 600000;

    sha256_byte_stream_hasher_unit uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .data_byte(data_byte),
        .has_byte(has_byte),
        .is_last(is_last),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .digest_word(digest_word),
        .word_index(word_index),
        .last_word(last_word),
        .out_valid(out_valid),
        .out_stall(out_stall)
    );

    always #10 clk = ~clk;

    // Watchdog: the run must finish well inside the limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output monitor: a beat moves when valid is high and stall is low.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_word(digest_word, word_index, last_word);
    end

    // Receiver stall pattern: a randomly redrawn mode makes some stretches never
    // stall, others stall lightly, heavily or in runs.
    int stall_mode = 0;
    int stall_run = 0;
    always @(posedge clk)
    begin
        if (cycle_count % 300 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 25);
            2: out_stall <= ($urandom_range(0, 99) < 70);
            default:
            begin
                if (stall_run == 0) stall_run = $urandom_range(1, 12);
                stall_run--;
                out_stall <= (stall_run > 4);
            end
        endcase
    end

    // One input beat; valid stays high into the next beat of a burst.
    task automatic send_beat(input logic [7:0] d, input logic h, input logic l);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        data_byte <= d;
        has_byte  <= h;
        is_last   <= l;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_beat(d, h, l);
        item_count++;
    endtask

    // A message of len random bytes; the end marker rides on the last byte
    // or on a separate empty beat. Occasional dropped beats as noise.
    task automatic send_message(input int len, input bit last_on_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b1, last_on_byte && (i == len - 1));
        end
        if (!last_on_byte || len == 0)
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Hold off the sender until every owed digest beat has come back.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.owed_q.size() != 0) @(posedge clk);
    endtask

    int len;
    int boundary_lens [6] = '{55, 56, 57, 63, 64, 65};

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, lone byte+last at both extremes,
        // byte then empty last, dropped beat with garbage data, "abc".
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'h5a, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'ha5, 1'b0, 1'b1);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        drain();

        // Random messages: mostly short, some at the padding boundaries.
        while (item_count < 160)
        begin
            if ($urandom_range(0, 3) == 0)
                len = boundary_lens[$urandom_range(0, 5)];
            else
                len = $urandom_range(0, 9);
            if (len > 160 - item_count)
                len = 160 - item_count;
            send_message(len, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0) drain();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.owed_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sha256_byte_stream_hasher_unit.f =====
+incdir+hdl
hdl/shb_pkg.sv
hdl/shb_front.sv
hdl/shb_back.sv
hdl/sha256_byte_stream_hasher_unit.sv
hdl/shb_checker.sv
verif/tb_sha256_byte_stream_hasher_unit.sv
